// ===== hw/rtl/two_level_priority_task_queue_assert.svh =====
// Assertion macros for the task queue RTL.
// Depends on nothing; included by two_level_priority_task_queue, which carries the checks.
`ifndef TWO_LEVEL_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_TASK_QUEUE_ASSERT_SVH

// Condition holds at every edge outside reset
`define TLPQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define TLPQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TLPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tlpq_pkg.sv =====
// Package for the two-level task queue: sizes, codes and shared types.
// Depends on nothing.
package tlpq_pkg;

   // Storage sizes
   localparam int FIFO_DEPTH     = 16;
   localparam int PRIORITY_DEPTH = 16;
   localparam int HANDLE_BITS    = 16;
   localparam int PRIORITY_BITS  = 8;

   localparam int FIFO_IDX_BITS  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);
   localparam int PRIO_CNT_BITS  = $clog2(PRIORITY_DEPTH + 1);

   // Beat field widths
   localparam int COMMAND_BITS      = 2;
   localparam int HANDLE_FIELD_BITS = 16;
   localparam int PRIO_FIELD_BITS   = 8;
   localparam int STATUS_BITS       = 2;
   localparam int OCC_BITS          = 5;

   // Request command codes
   typedef enum logic [COMMAND_BITS-1:0] {
      CMD_PUSH_FIFO = 2'd0,
      CMD_PUSH_PRIO = 2'd1,
      CMD_POP       = 2'd2
   } command_type;

   // Response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   // Operation broadcast to every cell of the sorted list
   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_SHIFT
   } chain_op_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0]   handle;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   // What a cell shows its neighbors
   typedef struct packed {
      entry_type entry;
      logic      keep;   // occupied and not displaced by the new entry
   } link_type;

endpackage

// ===== hw/rtl/tlpq_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on tlpq_pkg.
interface tlpq_req_if import tlpq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [COMMAND_BITS-1:0]      command;
   logic [HANDLE_FIELD_BITS-1:0] task_handle;
   logic [PRIO_FIELD_BITS-1:0]   task_priority;

   modport source (output valid, command, task_handle, task_priority, input ready);
   modport sink   (input valid, command, task_handle, task_priority, output ready);
endinterface

interface tlpq_rsp_if import tlpq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_BITS-1:0]       status;
   logic [HANDLE_FIELD_BITS-1:0] popped_handle;
   logic [PRIO_FIELD_BITS-1:0]   popped_priority;
   logic                         from_priority_list;
   logic [OCC_BITS-1:0]          fifo_occupancy;
   logic [OCC_BITS-1:0]          priority_occupancy;

   modport source (output valid, status, popped_handle, popped_priority,
                   from_priority_list, fifo_occupancy, priority_occupancy,
                   input ready);
   modport sink   (input valid, status, popped_handle, popped_priority,
                   from_priority_list, fifo_occupancy, priority_occupancy,
                   output ready);
endinterface

// ===== hw/rtl/two_level_priority_task_queue.sv =====
// Latency: a request beat's response is valid the cycle after it is accepted.
// Throughput: one beat per cycle when responses are taken; a priority insert
// is done by the cell row, a FIFO pop by the single registered memory read.
// Reset: synchronous; clears counts, pointers and response valid. Stored
// entries are not cleared and need no clearing pass.
module two_level_priority_task_queue import tlpq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tlpq_req_if.sink   req_bus,
   tlpq_rsp_if.source rsp_bus
);

`include "two_level_priority_task_queue_assert.svh"

   logic                     accept;
   entry_type                new_entry;
   entry_type                head_entry;
   chain_op_type             chain_op;
   logic [PRIO_CNT_BITS-1:0] prio_count;
   logic                     prio_full;
   logic                     fifo_push, fifo_pop, fifo_full;
   logic [FIFO_CNT_BITS-1:0] fifo_count;
   logic [HANDLE_BITS-1:0]   fifo_rd_handle;

   // Response stage
   logic                     rsp_valid_ff;
   status_type               status_ff, status_in;
   logic [HANDLE_BITS-1:0]   handle_ff, handle_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     from_prio_ff, from_prio_in;
   logic                     from_fifo_ff, from_fifo_in;
   logic [OCC_BITS-1:0]      fifo_occ_ff, fifo_occ_in;
   logic [OCC_BITS-1:0]      prio_occ_ff, prio_occ_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign new_entry     = '{handle: HANDLE_BITS'(req_bus.task_handle),
                            prio:   PRIORITY_BITS'(req_bus.task_priority)};

   tlpq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .op         (chain_op),
      .new_entry  (new_entry),
      .head_entry (head_entry),
      .count      (prio_count),
      .full       (prio_full)
   );

   tlpq_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (fifo_push),
      .push_handle (new_entry.handle),
      .pop         (fifo_pop),
      .rd_handle   (fifo_rd_handle),
      .count       (fifo_count),
      .full        (fifo_full)
   );

   // Command decode; state changes only on an accepted beat
   always_comb begin
      fifo_push    = 1'b0;
      fifo_pop     = 1'b0;
      chain_op     = CHAIN_HOLD;
      status_in    = ST_OK;
      handle_in    = '0;
      prio_in      = '0;
      from_prio_in = 1'b0;
      from_fifo_in = 1'b0;
      case (req_bus.command)
         CMD_PUSH_FIFO: begin
            if (fifo_full) status_in = ST_DROPPED;
            else fifo_push = accept;
         end
         CMD_PUSH_PRIO: begin
            if (prio_full) status_in = ST_DROPPED;
            else if (accept) chain_op = CHAIN_INSERT;
         end
         CMD_POP: begin
            if (prio_count != '0) begin
               if (accept) chain_op = CHAIN_SHIFT;
               handle_in    = head_entry.handle;
               prio_in      = head_entry.prio;
               from_prio_in = 1'b1;
            end else if (fifo_count != '0) begin
               fifo_pop     = accept;
               from_fifo_in = 1'b1;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // Occupancy after this beat
   always_comb begin
      fifo_occ_in = OCC_BITS'(fifo_count);
      prio_occ_in = OCC_BITS'(prio_count);
      if (fifo_push) fifo_occ_in = OCC_BITS'(fifo_count) + 1'b1;
      if (fifo_pop)  fifo_occ_in = OCC_BITS'(fifo_count) - 1'b1;
      if (chain_op == CHAIN_INSERT) prio_occ_in = OCC_BITS'(prio_count) + 1'b1;
      if (chain_op == CHAIN_SHIFT)  prio_occ_in = OCC_BITS'(prio_count) - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         handle_ff    <= handle_in;
         prio_ff      <= prio_in;
         from_prio_ff <= from_prio_in;
         from_fifo_ff <= from_fifo_in;
         fifo_occ_ff  <= fifo_occ_in;
         prio_occ_ff  <= prio_occ_in;
      end
   end

   // FIFO pops take the handle straight from the memory read register
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.status             = status_ff;
   assign rsp_bus.popped_handle      = from_fifo_ff ? HANDLE_FIELD_BITS'(fifo_rd_handle)
                                                    : HANDLE_FIELD_BITS'(handle_ff);
   assign rsp_bus.popped_priority    = PRIO_FIELD_BITS'(prio_ff);
   assign rsp_bus.from_priority_list = from_prio_ff;
   assign rsp_bus.fifo_occupancy     = fifo_occ_ff;
   assign rsp_bus.priority_occupancy = prio_occ_ff;

   `TLPQ_ASSERT_ALWAYS(a_fifo_bound, clock, reset,
      fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH), "FIFO count past depth")
   `TLPQ_ASSERT_NEXT(a_accept_rsp, clock, reset, accept,
      rsp_bus.valid, "accepted beat gave no response")
   `TLPQ_ASSERT_NEXT(a_prio_first, clock, reset,
      accept && (req_bus.command == CMD_POP) && (prio_count != '0),
      rsp_bus.from_priority_list && (rsp_bus.status == ST_OK),
      "pop skipped a non-empty sorted list")
   `TLPQ_ASSERT_IMPLY(a_empty_zero, clock, reset,
      rsp_bus.valid && (rsp_bus.status == ST_EMPTY),
      (rsp_bus.popped_handle == '0) && !rsp_bus.from_priority_list,
      "empty pop carried a task")

endmodule

// ===== hw/rtl/tlpq_cell.sv =====
// One slot of the sorted list: holds an entry, shifts left or right.
// Depends on tlpq_pkg.
module tlpq_cell import tlpq_pkg::*; (
   input  logic         clock,
   input  chain_op_type op,
   input  entry_type    new_entry,
   input  logic         occupied,
   input  link_type     left_link,
   input  entry_type    right_entry,
   output link_type     link
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      keep;

   // Entry stays put if it is at least as urgent as the newcomer
   assign keep = occupied && (entry_ff.prio <= new_entry.prio);
   assign link = '{entry: entry_ff, keep: keep};

   always_comb begin
      case (op)
         CHAIN_INSERT: begin
            if (keep) begin
               entry_in = entry_ff;
            end else if (left_link.keep) begin
               entry_in = new_entry;
            end else begin
               entry_in = left_link.entry;
            end
         end
         CHAIN_SHIFT: entry_in = right_entry;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/tlpq_chain.sv =====
// Sorted list as a row of cells, head at cell 0, plus its fill count.
// Depends on tlpq_pkg and tlpq_cell.
module tlpq_chain import tlpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  chain_op_type             op,
   input  entry_type                new_entry,
   output entry_type                head_entry,
   output logic [PRIO_CNT_BITS-1:0] count,
   output logic                     full
);

   link_type                 links [PRIORITY_DEPTH];
   logic [PRIO_CNT_BITS-1:0] count_ff;
   logic [PRIO_CNT_BITS-1:0] count_in;

   // Row of cells; cell 0 sees a pinned neighbor that always keeps
   for (genvar i = 0; i < PRIORITY_DEPTH; i++) begin : g_cell
      link_type  left_link;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_link = '{entry: new_entry, keep: 1'b1};
      end else begin : g_mid
         assign left_link = links[i-1];
      end

      if (i == PRIORITY_DEPTH - 1) begin : g_last
         assign right_entry = links[i].entry;
      end else begin : g_inner
         assign right_entry = links[i+1].entry;
      end

      tlpq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .new_entry   (new_entry),
         .occupied    (PRIO_CNT_BITS'(i) < count_ff),
         .left_link   (left_link),
         .right_entry (right_entry),
         .link        (links[i])
      );
   end

   // Fill count
   always_comb begin
      count_in = count_ff;
      case (op)
         CHAIN_INSERT: if (!full) count_in = count_ff + 1'b1;
         CHAIN_SHIFT:  if (count_ff != '0) count_in = count_ff - 1'b1;
         default:      count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_entry = links[0].entry;
   assign count      = count_ff;
   assign full       = (count_ff == PRIO_CNT_BITS'(PRIORITY_DEPTH));

endmodule

// ===== hw/rtl/tlpq_fifo.sv =====
// Plain FIFO of task handles with a registered read port.
// Depends on tlpq_pkg.
module tlpq_fifo import tlpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [HANDLE_BITS-1:0]   push_handle,
   input  logic                     pop,
   output logic [HANDLE_BITS-1:0]   rd_handle,
   output logic [FIFO_CNT_BITS-1:0] count,
   output logic                     full
);

   logic [HANDLE_BITS-1:0]   mem [FIFO_DEPTH];
   logic [HANDLE_BITS-1:0]   rd_ff;
   logic [FIFO_IDX_BITS-1:0] head_ff, head_in;
   logic [FIFO_IDX_BITS-1:0] tail_ff, tail_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   localparam logic [FIFO_IDX_BITS-1:0] LAST_IDX = FIFO_IDX_BITS'(FIFO_DEPTH - 1);

   // Pointer and count update, wrapping at the last slot
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_handle;
      end
      if (pop) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign rd_handle = rd_ff;
   assign count     = count_ff;
   assign full      = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));

endmodule

// ===== sim/tb_two_level_priority_task_queue.sv =====
// Self-checking testbench for the two-level task queue: a scoreboard class
// predicts each response beat from the accepted request beats.
// Depends on tlpq_pkg, tlpq_if and two_level_priority_task_queue.
`timescale 1ns / 100ps

module tb_two_level_priority_task_queue import tlpq_pkg::*; ;

   // One expected or observed response beat
   typedef struct packed {
      status_type                   status;
      logic [HANDLE_FIELD_BITS-1:0] handle;
      logic [PRIO_FIELD_BITS-1:0]   prio;
      logic                         from_list;
      logic [OCC_BITS-1:0]          fifo_occ;
      logic [OCC_BITS-1:0]          prio_occ;
   } rsp_beat_type;

   // Mirrors both queue parts and holds the responses still owed by the block
   class queue_tracker_type;
      logic [HANDLE_FIELD_BITS-1:0] fifo_handles[$];
      entry_type                    sorted_tasks[$];
      rsp_beat_type                 expected_rsp[$];
      int unsigned                  mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int unsigned outstanding();
         return expected_rsp.size();
      endfunction

      function void report_mismatch(string what, int unsigned exp_val,
                                    int unsigned act_val);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what,
                     exp_val, act_val);
      endfunction

      // Update the queue mirror for one accepted request and queue its response
      function void predict_request(logic [COMMAND_BITS-1:0] cmd,
                                    logic [HANDLE_FIELD_BITS-1:0] handle,
                                    logic [PRIO_FIELD_BITS-1:0] prio);
         rsp_beat_type rsp;
         entry_type    ent;
         int           slot;
         int           i;
         rsp        = '0;
         rsp.status = ST_OK;
         ent.handle = handle[HANDLE_BITS-1:0];
         ent.prio   = prio[PRIORITY_BITS-1:0];
         if (cmd == CMD_PUSH_FIFO) begin
            if (fifo_handles.size() >= FIFO_DEPTH)
               rsp.status = ST_DROPPED;
            else
               fifo_handles = {fifo_handles, ent.handle};
         end else if (cmd == CMD_PUSH_PRIO) begin
            if (sorted_tasks.size() >= PRIORITY_DEPTH) begin
               rsp.status = ST_DROPPED;
            end else begin
               // goes ahead of the first strictly larger priority number
               slot = 0;
               while (slot < sorted_tasks.size() && sorted_tasks[slot].prio <= ent.prio)
                  slot++;
               sorted_tasks = {sorted_tasks, ent};
               for (i = sorted_tasks.size() - 1; i > slot; i--)
                  sorted_tasks[i] = sorted_tasks[i-1];
               sorted_tasks[slot] = ent;
            end
         end else if (cmd == CMD_POP) begin
            // sorted list wins, FIFO is the fallback
            if (sorted_tasks.size() != 0) begin
               ent = sorted_tasks[0];
               sorted_tasks.delete(0);
               rsp.handle    = ent.handle;
               rsp.prio      = ent.prio;
               rsp.from_list = 1'b1;
            end else if (fifo_handles.size() != 0) begin
               rsp.handle = fifo_handles[0];
               fifo_handles.delete(0);
            end else begin
               rsp.status = ST_EMPTY;
            end
         end
         rsp.fifo_occ = OCC_BITS'(fifo_handles.size());
         rsp.prio_occ = OCC_BITS'(sorted_tasks.size());
         expected_rsp = {expected_rsp, rsp};
      endfunction

      // Compare one accepted response beat against the oldest expectation
      function void check_response(rsp_beat_type got);
         rsp_beat_type exp;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", 0, 1);
            return;
         end
         exp = expected_rsp[0];
         expected_rsp.delete(0);
         if (got.status != exp.status)
            report_mismatch("status", exp.status, got.status);
         if (got.handle != exp.handle)
            report_mismatch("popped_handle", exp.handle, got.handle);
         if (got.prio != exp.prio)
            report_mismatch("popped_priority", exp.prio, got.prio);
         if (got.from_list != exp.from_list)
            report_mismatch("from_priority_list", exp.from_list, got.from_list);
         if (got.fifo_occ != exp.fifo_occ)
            report_mismatch("fifo_occupancy", exp.fifo_occ, got.fifo_occ);
         if (got.prio_occ != exp.prio_occ)
            report_mismatch("priority_occupancy", exp.prio_occ, got.prio_occ);
      endfunction
   endclass

   localparam logic [COMMAND_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned SEGMENT_LEN  = 30;
   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned DRAIN_CYCLES = 16;

   // Flavor of a random stretch of requests
   typedef enum int unsigned {
      MIX_FILL_FIFO,
      MIX_FILL_PRIO,
      MIX_DRAIN,
      MIX_BALANCED
   } mix_type;

   logic              clock;
   logic              reset;
   int unsigned       req_idle_pct;
   int unsigned       rsp_idle_pct;
   bit                hold_go;
   int unsigned       cycle_count;
   queue_tracker_type tracker;

   tlpq_req_if req_bus ();
   tlpq_rsp_if rsp_bus ();

   two_level_priority_task_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Offer one request beat, idling first at random, and wait for acceptance
   task automatic send_request(input logic [COMMAND_BITS-1:0] cmd,
                               input logic [HANDLE_FIELD_BITS-1:0] handle,
                               input logic [PRIO_FIELD_BITS-1:0] prio);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.task_handle   <= handle;
      req_bus.task_priority <= prio;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      tracker.predict_request(cmd, handle, prio);
   endtask

   // A quarter few distinct priorities so ties show up, a quarter extremes, the rest any
   function automatic logic [PRIO_FIELD_BITS-1:0] pick_priority();
      case ($urandom_range(3))
         0:       return PRIO_FIELD_BITS'($urandom_range(3));
         1:       return $urandom_range(1) ? '1 : '0;
         default: return PRIO_FIELD_BITS'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [COMMAND_BITS-1:0] pick_command(mix_type mode);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return CMD_UNUSED;
      case (mode)
         MIX_FILL_FIFO:
            return (roll < 85) ? CMD_PUSH_FIFO : (roll < 92) ? CMD_PUSH_PRIO : CMD_POP;
         MIX_FILL_PRIO:
            return (roll < 85) ? CMD_PUSH_PRIO : (roll < 92) ? CMD_PUSH_FIFO : CMD_POP;
         MIX_DRAIN:
            return (roll < 85) ? CMD_POP : (roll < 92) ? CMD_PUSH_FIFO : CMD_PUSH_PRIO;
         default:
            return (roll < 36) ? CMD_PUSH_FIFO : (roll < 68) ? CMD_PUSH_PRIO : CMD_POP;
      endcase
   endfunction

   // Random traffic in stretches that fill one part, drain, or mix
   task automatic run_random(input int unsigned count);
      mix_type mode;
      mode = MIX_BALANCED;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % SEGMENT_LEN == 0)
            mode = mix_type'($urandom_range(3));
         send_request(pick_command(mode), HANDLE_FIELD_BITS'($urandom), pick_priority());
      end
   endtask

   // Response side: check accepted beats, stall at random or for a long hold
   initial begin
      int unsigned  hold_left;
      bit           hold_done;
      rsp_beat_type got;
      hold_left     = 0;
      hold_done     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               got.status    = status_type'(rsp_bus.status);
               got.handle    = rsp_bus.popped_handle;
               got.prio      = rsp_bus.popped_priority;
               got.from_list = rsp_bus.from_priority_list;
               got.fifo_occ  = rsp_bus.fifo_occupancy;
               got.prio_occ  = rsp_bus.priority_occupancy;
               tracker.check_response(got);
            end
            if (hold_go && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1;
            end
            if (hold_left > 0) begin
               rsp_bus.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
         end
      end
   end

   // Stimulus
   initial begin
      tracker               = new();
      req_idle_pct          = 28;
      rsp_idle_pct          = 60;
      hold_go               = 0;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_PUSH_FIFO;
      req_bus.task_handle   = '0;
      req_bus.task_priority = '0;
      reset                 = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // pop with both parts empty, then an unused code on an empty queue
      send_request(CMD_POP, 16'h0000, 8'h00);
      send_request(CMD_UNUSED, 16'hFFFF, 8'hFF);
      // FIFO pushes with extreme handles
      send_request(CMD_PUSH_FIFO, 16'h0000, 8'hFF);
      send_request(CMD_PUSH_FIFO, 16'hFFFF, 8'h00);
      // sorted pushes: extremes, ties at head and tail
      send_request(CMD_PUSH_PRIO, 16'h1234, 8'hFF);
      send_request(CMD_PUSH_PRIO, 16'hFFFF, 8'h00);
      send_request(CMD_PUSH_PRIO, 16'h0000, 8'h00);
      send_request(CMD_PUSH_PRIO, 16'hA5A5, 8'h80);
      send_request(CMD_PUSH_PRIO, 16'h5A5A, 8'hFF);
      // unused code must leave nonzero occupancies alone
      send_request(CMD_UNUSED, 16'h00FF, 8'h0F);
      // drain the sorted list, then the FIFO, then one more empty pop
      repeat (5) send_request(CMD_POP, 16'hFFFF, 8'hFF);
      repeat (2) send_request(CMD_POP, 16'h0000, 8'h00);
      send_request(CMD_POP, 16'h0000, 8'h00);

      run_random(RANDOM_ITEMS / 3);
      req_idle_pct = 60;
      rsp_idle_pct = 28;
      run_random(RANDOM_ITEMS / 3);
      // no idling; the response side holds off once so the input backs up
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_go      = 1;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
